/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, checked while out of reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/rfg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rfg_pkg;

  // item kinds, carried on the slave tuser
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_TONE  = 2'd2,
    KIND_READ  = 2'd3
  } rfg_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TONE,
    ST_TONE_FLUSH,
    ST_RD_MEM,
    ST_RD_OUT
  } rfg_state_e;

  // controller to datapath
  typedef struct packed {
    logic pix_wr;
    logic rd_cap;
    logic rd_mem;
    logic clr_start;
    logic clr_wr;
    logic tone_start;
    logic tone_rd;
    logic out_load;
  } rfg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic tone_empty;
    logic out_busy;
  } rfg_status_t;

  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [7:0] DIM_RESET      = 8'd128;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

  typedef logic [255:0][7:0] rfg_gamma_rom_t;

  // largest c with (2c+1)^11 <= (2v+1)^5 * 2^54, i.e. the 1/2.2 power curve
  function automatic rfg_gamma_rom_t build_gamma();
    rfg_gamma_rom_t rom;
    logic [127:0]   rhs;
    logic [127:0]   lhs;
    int             v;
    int             k;
    int             c;
    logic           more;
    rom = '0;
    c   = 0;
    for (v = 0; v < 256; v++) begin
      rhs = 128'd1;
      for (k = 0; k < 5; k++) begin
        rhs = rhs * 128'(2 * v + 1);
      end
      rhs  = rhs << 54;
      more = 1'b1;
      while (more) begin
        if (c == 255) begin
          more = 1'b0;
        end else begin
          lhs = 128'd1;
          for (k = 0; k < 11; k++) begin
            lhs = lhs * 128'(2 * c + 3);
          end
          if (lhs <= rhs) begin
            c = c + 1;
          end else begin
            more = 1'b0;
          end
        end
      end
      rom[v] = c[7:0];
    end
    return rom;
  endfunction

  localparam rfg_gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

`default_nettype wire

/* hdl/rgb_framebuffer_gamma_readout.sv */
// RGB framebuffer with 2.2 gamma readout.
// Slave stream: tuser carries the item kind (write, clear, tone pass, read);
// tdata carries column, row and the three Q4.12 colours of a write.
// Master stream: one word per read; tuser flags an in-frame read, tdata
// holds the gamma-mapped red, green, blue bytes and an opaque alpha byte.
// Config port: cfg_we_i writes frame width (index 0) or height (index 1).
// Throughput: a pixel write is taken every cycle while no clear, tone pass
// or read is under way. A read holds off the next item through its steps:
// address multiply, pixel memory read, gamma rom into the output register.
// A clear sweeps all MAX_WIDTH*MAX_HEIGHT pixels one pixel a cycle. A tone
// pass is a read-modify-write sweep over the W*H pixels in use; both
// sweeps write through the single write port of the pixel memory.
// Reset: the frame size returns to 128x128 and a clearing pass over all
// MAX_WIDTH*MAX_HEIGHT pixels (16384 by default) runs with s_axis_tready low.
// Stall: a waiting read word holds on the master side while writes, clears
// and tone passes continue; a further read waits until that word is taken.
`timescale 1ns / 1ps
`default_nettype none

module rgb_framebuffer_gamma_readout import rfg_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  // command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // column, row, red_in, green_in, blue_in
  input  wire logic [1:0]  s_axis_tuser,  // kind
  // read result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic [0:0]       m_axis_tuser   // read_ok
);

  rfg_cmd_t    cmd;
  rfg_status_t status;
  logic        read_ok;
  logic [7:0]  red_out, green_out, blue_out;

  // sequencing of sweeps, reads and the output handshake
  rfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .kind_i     (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // pixel memory, address math, gamma rom and output register
  rfg_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .column_i    (s_axis_tdata[11:0]),
    .row_i       (s_axis_tdata[23:12]),
    .red_i       (s_axis_tdata[39:24]),
    .green_i     (s_axis_tdata[55:40]),
    .blue_i      (s_axis_tdata[71:56]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .read_ok_o   (read_ok),
    .red_o       (red_out),
    .green_o     (green_out),
    .blue_o      (blue_out)
  );

  // alpha is always opaque
  assign m_axis_tdata = {ALPHA_OPAQUE, blue_out, green_out, red_out};
  assign m_axis_tuser = read_ok;

endmodule

`default_nettype wire

/* hdl/rfg_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rfg_ctrl import rfg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [1:0]  kind_i,
  output logic             in_ready_o,
  input  wire rfg_status_t status_i,
  output rfg_cmd_t         cmd_o
);

  rfg_state_e state_q, state_d;

  // reset starts with a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (rfg_kind_e'(kind_i))
            KIND_WRITE: cmd_o.pix_wr = 1'b1;
            KIND_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = ST_CLEAR;
            end
            KIND_TONE: begin
              if (!status_i.tone_empty) begin
                cmd_o.tone_start = 1'b1;
                state_d          = ST_TONE;
              end
            end
            KIND_READ: begin
              cmd_o.rd_cap = 1'b1;
              state_d      = ST_RD_MEM;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_TONE: begin
        cmd_o.tone_rd = 1'b1;
        if (status_i.sweep_last) state_d = ST_TONE_FLUSH;
      end
      ST_TONE_FLUSH: state_d = ST_IDLE;
      ST_RD_MEM: begin
        cmd_o.rd_mem = 1'b1;
        state_d      = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/rfg_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module rfg_datapath import rfg_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic signed [11:0] column_i,
  input  wire logic signed [11:0] row_i,
  input  wire logic signed [15:0] red_i,
  input  wire logic signed [15:0] green_i,
  input  wire logic signed [15:0] blue_i,
  input  wire rfg_cmd_t           cmd_i,
  output rfg_status_t             status_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic                    read_ok_o,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o
);

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam logic [AW-1:0] LAST_PIX = AW'(NPIX - 1);

  function automatic logic [7:0] q412_to_byte(input logic [15:0] q);
    logic [7:0] b;
    if (q[15]) begin
      b = 8'd0;
    end else if (q[14:12] != 3'd0) begin
      b = 8'd255;
    end else begin
      b = q[11:4];
    end
    return b;
  endfunction

  logic [7:0]    width_q, height_q;
  logic [7:0]    eff_w, eff_h;
  logic          in_frame;
  logic [7:0]    arow;
  logic [15:0]   addr_full;
  logic [AW-1:0] pix_addr;
  logic [15:0]   tone_n;
  logic [AW-1:0] tone_last;
  logic [23:0]   wr_pixel;

  logic [23:0]   mem_q [NPIX];
  logic [23:0]   rdata_q;
  logic [23:0]   mapped;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [23:0]   mem_wdata;

  logic [AW-1:0] sweep_q, last_q;
  logic          sweep_last;
  logic          tone_wr_q;
  logic [AW-1:0] tone_addr_q;
  logic [AW-1:0] rd_addr_q;
  logic          rd_ok_q;
  logic          out_valid_q;
  logic          read_ok_q;
  logic [23:0]   out_pix_q;

  // frame size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IDX_WIDTH)  width_q  <= cfg_data_i;
      if (cfg_idx_i == CFG_IDX_HEIGHT) height_q <= cfg_data_i;
    end
  end

  assign eff_w = (32'(width_q) > MAX_WIDTH) ? 8'(MAX_WIDTH) : width_q;
  assign eff_h = (32'(height_q) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : height_q;

  assign in_frame = !column_i[11] && !row_i[11] &&
                    (column_i[10:0] < 11'(eff_w)) && (row_i[10:0] < 11'(eff_h));

  // reads count rows from the bottom of the store
  assign arow      = cmd_i.rd_cap ? (eff_h - 8'd1 - row_i[7:0]) : row_i[7:0];
  assign addr_full = 16'(arow) * 16'(eff_w) + 16'(column_i[7:0]);
  assign pix_addr  = AW'(addr_full);

  assign tone_n    = 16'(eff_w) * 16'(eff_h);
  assign tone_last = AW'(tone_n - 16'd1);

  assign wr_pixel = {q412_to_byte(blue_i), q412_to_byte(green_i), q412_to_byte(red_i)};

  assign mapped = {GAMMA_ROM[rdata_q[23:16]], GAMMA_ROM[rdata_q[15:8]],
                   GAMMA_ROM[rdata_q[7:0]]};

  assign sweep_last = (sweep_q == last_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = wr_pixel;
    if (cmd_i.pix_wr && in_frame) begin
      mem_we = 1'b1;
    end else if (cmd_i.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_q;
      mem_wdata = '0;
    end else if (tone_wr_q) begin
      mem_we    = 1'b1;
      mem_waddr = tone_addr_q;
      mem_wdata = mapped;
    end
  end

  assign mem_re    = cmd_i.tone_rd | cmd_i.rd_mem;
  assign mem_raddr = cmd_i.tone_rd ? sweep_q : rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  // sweep counter for clear and tone passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q   <= '0;
      last_q    <= LAST_PIX;
      tone_wr_q <= 1'b0;
    end else begin
      tone_wr_q <= cmd_i.tone_rd;
      if (cmd_i.clr_start) begin
        sweep_q <= '0;
        last_q  <= LAST_PIX;
      end else if (cmd_i.tone_start) begin
        sweep_q <= '0;
        last_q  <= tone_last;
      end else if (cmd_i.clr_wr || cmd_i.tone_rd) begin
        sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tone_rd) tone_addr_q <= sweep_q;
    if (cmd_i.rd_cap) begin
      rd_addr_q <= pix_addr;
      rd_ok_q   <= in_frame;
    end
    if (cmd_i.out_load) begin
      read_ok_q <= rd_ok_q;
      out_pix_q <= rd_ok_q ? mapped : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.sweep_last = sweep_last;
  assign status_o.tone_empty = (eff_w == 8'd0) || (eff_h == 8'd0);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign read_ok_o   = read_ok_q;
  assign red_o       = out_pix_q[7:0];
  assign green_o     = out_pix_q[15:8];
  assign blue_o      = out_pix_q[23:16];

endmodule

`default_nettype wire

/* hdl/rfg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rfg_checker import rfg_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  logic take_clear, take_read;

  assign take_clear = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_CLEAR);
  assign take_read  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_READ);

  // stalled read word holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // alpha byte is opaque on every word
  `ASSERT_IMPL(a_alpha, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[31:24] == ALPHA_OPAQUE)
  // reads not flagged as in-frame carry black
  `ASSERT_IMPL(a_flag_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[23:0] == 24'd0)
  // a clear sweep blocks the command stream
  `ASSERT_NEXT(a_clear_busy, clk_i, rst_ni, take_clear, !s_axis_tready)
  // a read blocks the command stream while the memory is read
  `ASSERT_NEXT(a_read_busy, clk_i, rst_ni, take_read, !s_axis_tready)

endmodule

bind rgb_framebuffer_gamma_readout rfg_checker u_rfg_checker (.*);

`default_nettype wire
